@@ rtl/mat4_pkg.sv @@
// Shared constants, types and command/status structs for the 4x4 matrix multiplier.
package mat4_pkg;

    localparam int ELEMENT_WIDTH = 32;
    localparam int FRACTION_BITS = 16;
    localparam int DIM           = 4;
    localparam int COORD_W       = 2;
    localparam int IDX_W         = 4;

    // A product after dropping the fraction bits, and the four-term sum of those.
    localparam int PROD_W = 2 * ELEMENT_WIDTH - FRACTION_BITS;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    localparam int S_TDATA_W = ((2 * ELEMENT_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((ELEMENT_WIDTH + IDX_W + 7) / 8) * 8;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM * DIM - 1);

    typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;
    typedef logic [IDX_W-1:0]                idx_t;

    typedef enum logic [2:0] {
        ST_LOAD    = 3'b001,
        ST_COMPUTE = 3'b010,
        ST_DRAIN   = 3'b100
    } state_t;

    typedef struct packed {
        logic load_we;
        idx_t load_pos;
        logic issue;
        idx_t issue_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic advance;
        logic busy;
    } dp_status_t;

endpackage

@@ rtl/mat4_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mat4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mat4_ctrl.sv @@
// Controller: load counter, product issue counter and run state machine.
module mat4_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  mat4_pkg::dp_status_t status,
    output mat4_pkg::dp_cmd_t    cmd
);
    import mat4_pkg::*;

    state_t state_reg, state_next;
    idx_t   load_pos_reg, load_pos_next;
    idx_t   issue_idx_reg, issue_idx_next;
    logic   load_beat;
    logic   issue_now;

    assign s_tready  = (state_reg == ST_LOAD);
    assign load_beat = s_tready && s_tvalid;
    assign issue_now = (state_reg == ST_COMPUTE) && status.advance;

    always_comb
    begin
        state_next     = state_reg;
        load_pos_next  = load_pos_reg;
        issue_idx_next = issue_idx_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (load_beat)
                begin
                    load_pos_next = load_pos_reg + 1'b1;
                    if (load_pos_reg == LAST_IDX)
                    begin
                        state_next     = ST_COMPUTE;
                        issue_idx_next = '0;
                    end
                end
            end
            ST_COMPUTE:
            begin
                if (issue_now)
                begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                    if (issue_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                // Back to loading only once the last product has been taken.
                if (!status.busy)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            load_pos_reg  <= '0;
            issue_idx_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            load_pos_reg  <= load_pos_next;
            issue_idx_reg <= issue_idx_next;
        end
    end

    assign cmd.load_we   = load_beat;
    assign cmd.load_pos  = load_pos_reg;
    assign cmd.issue     = issue_now;
    assign cmd.issue_idx = issue_idx_reg;

endmodule

@@ rtl/mat4_dp.sv @@
// Datapath: banked matrix stores, four multipliers, adder tree and saturation.
module mat4_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mat4_pkg::elem_t        left_element,
    input  mat4_pkg::elem_t        right_element,
    input  mat4_pkg::dp_cmd_t      cmd,
    output mat4_pkg::dp_status_t   status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output mat4_pkg::elem_t        product_element,
    output mat4_pkg::idx_t         element_index,
    output logic                   last_element
);
    import mat4_pkg::*;

    // Left matrix is banked by column and addressed by row; right matrix is
    // banked by row and addressed by column, so term k of any dot product
    // comes from bank k of each side.
    logic [COORD_W-1:0] ld_row, ld_col, rd_row, rd_col;
    logic               advance;

    elem_t                    a_rd [DIM];
    elem_t                    b_rd [DIM];
    logic signed [2*ELEMENT_WIDTH-1:0] prod_reg [DIM];
    logic signed [2*ELEMENT_WIDTH-1:0] prod_next [DIM];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [PAIR_W-1:0] pair_next [2];
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [SUM_W-ELEMENT_WIDTH:0] sum_top;
    elem_t                    sat_val;
    elem_t                    out_data_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    idx_t idx1_reg, idx2_reg, idx3_reg, idx4_reg, out_idx_reg;

    assign ld_row  = cmd.load_pos[IDX_W-1:COORD_W];
    assign ld_col  = cmd.load_pos[COORD_W-1:0];
    assign rd_row  = cmd.issue_idx[IDX_W-1:COORD_W];
    assign rd_col  = cmd.issue_idx[COORD_W-1:0];

    // The whole pipeline moves only when the output register can take a beat.
    assign advance = !out_valid_reg || out_ready;

    for (genvar k = 0; k < DIM; k++)
    begin : g_bank
        mat4_ram #(
            .WIDTH(ELEMENT_WIDTH),
            .DEPTH(DIM)
        ) u_left_ram (
            .clk  (clk),
            .we   (cmd.load_we && (ld_col == COORD_W'(k))),
            .waddr(ld_row),
            .wdata(left_element),
            .re   (advance),
            .raddr(rd_row),
            .rdata(a_rd[k])
        );

        mat4_ram #(
            .WIDTH(ELEMENT_WIDTH),
            .DEPTH(DIM)
        ) u_right_ram (
            .clk  (clk),
            .we   (cmd.load_we && (ld_row == COORD_W'(k))),
            .waddr(ld_col),
            .wdata(right_element),
            .re   (advance),
            .raddr(rd_col),
            .rdata(b_rd[k])
        );

        assign prod_next[k] = a_rd[k] * b_rd[k];
    end

    // Dropping the low fraction bits is a floor shift of the exact product.
    always_comb
    begin
        for (int p = 0; p < 2; p++)
        begin
            pair_next[p] =
                PAIR_W'(signed'(prod_reg[2*p][2*ELEMENT_WIDTH-1:FRACTION_BITS]))
              + PAIR_W'(signed'(prod_reg[2*p+1][2*ELEMENT_WIDTH-1:FRACTION_BITS]));
        end
    end

    assign sum_next = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);

    // The sum fits when every bit above the element's sign bit matches it.
    assign sum_top = sum_reg[SUM_W-1:ELEMENT_WIDTH-1];

    always_comb
    begin
        if ((&sum_top) || !(|sum_top))
        begin
            sat_val = sum_reg[ELEMENT_WIDTH-1:0];
        end
        else if (sum_reg[SUM_W-1])
        begin
            sat_val = {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < DIM; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            pair_reg[0]  <= pair_next[0];
            pair_reg[1]  <= pair_next[1];
            sum_reg      <= sum_next;
            out_data_reg <= sat_val;
            idx1_reg     <= cmd.issue_idx;
            idx2_reg     <= idx1_reg;
            idx3_reg     <= idx2_reg;
            idx4_reg     <= idx3_reg;
            out_idx_reg  <= idx4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= cmd.issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    assign status.advance = advance;
    assign status.busy    = v1_reg || v2_reg || v3_reg || v4_reg || out_valid_reg;

    assign out_valid       = out_valid_reg;
    assign product_element = out_data_reg;
    assign element_index   = out_idx_reg;
    assign last_element    = (out_idx_reg == LAST_IDX);

endmodule

@@ rtl/matrix4x4_multiply.sv @@
// Top level of the streaming 4x4 signed fixed-point matrix multiplier.
// Sixteen beats load A and B in row-major order, one element of each per beat,
// one beat per cycle. The block then stops taking input and streams the sixteen
// elements of A*B in row-major order: after bank read, four parallel multipliers,
// two adder stages and saturation, one product element leaves per cycle while the
// output side is ready, set by the four multipliers working one dot product per
// cycle. Input is accepted again once the last product beat has been taken.
// Products are floored to the fraction width and the four-term sum saturates to
// the element range.
module matrix4x4_multiply (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // left_element [31:0], right_element [63:32]
    input  logic [mat4_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // product_element [31:0], element_index [35:32], zero fill above
    output logic [mat4_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import mat4_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    elem_t      product_element;
    idx_t       element_index;

    mat4_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    mat4_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .left_element   (s_tdata[ELEMENT_WIDTH-1:0]),
        .right_element  (s_tdata[2*ELEMENT_WIDTH-1:ELEMENT_WIDTH]),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .product_element(product_element),
        .element_index  (element_index),
        .last_element   (m_tlast)
    );

    assign m_tdata = M_TDATA_W'({element_index, product_element});

    // No product beat is offered while the block is loading.
    assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> !m_tvalid)
        else $error("product beat offered during load");

    // Nothing follows the last product beat of a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("product beat after end of run");

    // Issuing products and loading elements never overlap.
    assert property (@(posedge clk) disable iff (!rst_n) !(cmd.issue && cmd.load_we))
        else $error("issue during load");

endmodule

@@ test/matrix_product_checker.sv @@
// Checker for the 4x4 matrix multiplier: predicts each product beat and compares it on the output.
module matrix_product_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [mat4_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [mat4_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    output int                             failures,
    output int                             pending,
    output int                             checked,
    output int                             saturated
);
    timeunit 1ns;
    timeprecision 1ps;

    import mat4_pkg::*;

    localparam longint ELEM_MAX = (longint'(1) <<< (ELEMENT_WIDTH - 1)) - 1;
    localparam longint ELEM_MIN = -(longint'(1) <<< (ELEMENT_WIDTH - 1));

    typedef struct packed {
        elem_t value;
        idx_t  index;
        logic  last;
    } product_beat_t;

    product_beat_t product_queue[$];
    elem_t         left_store  [DIM*DIM];
    elem_t         right_store [DIM*DIM];
    idx_t          load_position;

    initial
    begin
        failures  = 0;
        pending   = 0;
        checked   = 0;
        saturated = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        failures++;
    endtask

    // Exact sum of the four floored products of one row of A and one column of B.
    function automatic longint dot_product_q16(input int row, input int col);
        longint acc;
        longint a;
        longint b;
        acc = 0;
        for (int k = 0; k < DIM; k++)
        begin
            a = left_store[row*DIM + k];
            b = right_store[k*DIM + col];
            acc += (a * b) >>> FRACTION_BITS;
        end
        return acc;
    endfunction

    task automatic predict_product();
        longint        sum;
        product_beat_t beat;
        for (int row = 0; row < DIM; row++)
        begin
            for (int col = 0; col < DIM; col++)
            begin
                sum = dot_product_q16(row, col);
                if (sum > ELEM_MAX)
                begin
                    sum = ELEM_MAX;
                    saturated++;
                end
                else if (sum < ELEM_MIN)
                begin
                    sum = ELEM_MIN;
                    saturated++;
                end
                beat.value = elem_t'(sum);
                beat.index = idx_t'(row*DIM + col);
                beat.last  = (beat.index == LAST_IDX);
                product_queue.push_back(beat);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        product_beat_t want;
        elem_t         got_value;
        idx_t          got_index;
        if (!rst_n)
        begin
            product_queue.delete();
            load_position = '0;
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_value = m_tdata[ELEMENT_WIDTH-1:0];
                got_index = m_tdata[ELEMENT_WIDTH +: IDX_W];
                if (product_queue.size() == 0)
                    report_mismatch($sformatf("unexpected product beat idx %0d value %h",
                                              got_index, got_value));
                else
                begin
                    want = product_queue.pop_front();
                    checked++;
                    if (got_value !== want.value)
                        report_mismatch($sformatf("element %0d: value %h, expected %h",
                                                  want.index, got_value, want.value));
                    if (got_index !== want.index)
                        report_mismatch($sformatf("element %0d: index %0d",
                                                  want.index, got_index));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("element %0d: tlast %b, expected %b",
                                                  want.index, m_tlast, want.last));
                    if (m_tdata[M_TDATA_W-1:ELEMENT_WIDTH+IDX_W] !== '0)
                        report_mismatch($sformatf("element %0d: nonzero fill bits in tdata",
                                                  want.index));
                end
            end
            if (s_tvalid && s_tready)
            begin
                left_store[load_position]  = s_tdata[ELEMENT_WIDTH-1:0];
                right_store[load_position] = s_tdata[2*ELEMENT_WIDTH-1:ELEMENT_WIDTH];
                if (load_position == LAST_IDX)
                    predict_product();
                load_position = load_position + 1'b1;
            end
            pending <= product_queue.size();
        end
    end

endmodule

@@ test/tb_matrix4x4_multiply.sv @@
// Testbench top for the 4x4 matrix multiplier: stimulus, handshake idling and the verdict.
module tb_matrix4x4_multiply;
    timeunit 1ns;
    timeprecision 1ps;

    import mat4_pkg::*;

    localparam int    RANDOM_PAIRS  = 22;
    localparam int    QUIET_PAIRS   = 3;
    localparam int    IDLE_LIMIT    = 4000;
    localparam elem_t Q_MAX         = 32'sh7FFF_FFFF;
    localparam elem_t Q_MIN         = 32'sh8000_0000;
    localparam elem_t Q_ONE         = 32'sh0001_0000;
    localparam elem_t Q_HALF        = 32'sh0000_8000;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    int failures;
    int pending;
    int checked;
    int saturated;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    int pairs_sent  = 0;
    int beats_sent  = 0;

    // Directed pair: saturation both ways, min times min, and flooring of negative products.
    elem_t directed_left [16] = '{Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                  Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                  Q_ONE, -Q_ONE, 1, -1,
                                  0, Q_HALF, -Q_HALF, Q_MAX};
    elem_t directed_right [16] = '{Q_MAX, Q_MIN, Q_ONE, -1,
                                   Q_MAX, Q_MIN, -Q_ONE, 1,
                                   Q_MAX, Q_MIN, 1, 0,
                                   Q_MAX, Q_MIN, Q_ONE + Q_HALF, 0};

    matrix4x4_multiply dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    matrix_product_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .failures  (failures),
        .pending   (pending),
        .checked   (checked),
        .saturated (saturated)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Output side back-pressure in bursts of random length.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (rst_n && stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left <= $urandom_range(0, 5);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("no beat moved for %0d cycles, %0d products still expected",
                 IDLE_LIMIT, pending);
        $display("matrix4x4_multiply regression: fail");
        $finish;
    end

    function automatic elem_t rand_element();
        elem_t v;
        case ($urandom_range(0, 9))
            0:       v = Q_MAX;
            1:       v = Q_MIN;
            2, 3, 4: v = $urandom;
            // Values within about four units keep most sums clear of saturation.
            default: v = int'($urandom_range(0, 524288)) - 262144;
        endcase
        return v;
    endfunction

    // Called at a rising edge; returns once the beat is taken and any idle gap is over.
    task automatic send_beat(input elem_t left, input elem_t right);
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        do
            @(posedge clk);
        while (!s_tready);
        beats_sent++;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic load_matrix_pair(input elem_t left[16], input elem_t right[16]);
        for (int i = 0; i < 16; i++)
            send_beat(left[i], right[i]);
        pairs_sent++;
    endtask

    initial
    begin
        elem_t left [16];
        elem_t right [16];
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 20;
        stall_pct = 20;
        load_matrix_pair(directed_left, directed_right);

        for (int p = 0; p < RANDOM_PAIRS; p++)
        begin
            if (p >= RANDOM_PAIRS - QUIET_PAIRS)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       gap_pct = 0;
                    1:       gap_pct = 10;
                    default: gap_pct = 35;
                endcase
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    default: stall_pct = 35;
                endcase
            end
            for (int i = 0; i < 16; i++)
            begin
                left[i]  = rand_element();
                right[i] = rand_element();
            end
            load_matrix_pair(left, right);
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("loaded %0d matrix pairs in %0d input beats under varied idling",
                 pairs_sent, beats_sent);
        $display("checked %0d product beats, %0d of them saturated", checked, saturated);
        if (failures == 0)
            $display("matrix4x4_multiply regression: pass");
        else
            $display("matrix4x4_multiply regression: fail");
        $finish;
    end

endmodule
